@@ hdl/mcin_pkg.sv @@
// shared types and constants for the max-channel image normalize block
`default_nettype none

package mcin_pkg;

  // width of one color channel
  localparam int unsigned ChanW = 8;
  // quotient bits produced by the divider, and bits retired per cycle
  localparam int unsigned DivSteps = ChanW;
  localparam int unsigned BitsPerCycle = 2;
  localparam int unsigned StepCycles = DivSteps / BitsPerCycle;
  localparam int unsigned CntW = (StepCycles > 1) ? $clog2(StepCycles) : 1;

  // request commands
  localparam logic CmdMeasure = 1'b0;
  localparam logic CmdRewrite = 1'b1;

  // full-scale channel and opaque alpha
  localparam logic [ChanW-1:0] ChanFull = 8'hff;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [CntW-1:0] step_cnt_t;

  // control from the sequencer to every lane
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/max_channel_image_normalize_core.sv @@
// top level of the max-channel image normalize block
`default_nettype none

// Contrast stretch of an ARGB image in two passes. Measure requests (cmd 0)
// do not hold off the input and give no result; the request marked last
// freezes the maximum over red, green and blue of all non-transparent pixels.
// Rewrite requests (cmd 1) give one pixel each. An opaque-side rewrite runs
// three lanes side by side, one divider per color, each retiring two quotient
// bits a cycle, and the result then goes into the result register. The input
// is held off until the rewrite's result has entered the result register, and
// longer while that register is stalled; a transparent rewrite skips the divider.
// A new request can enter while the previous result waits downstream.

module max_channel_image_normalize_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] pixel_in_i,
  input  logic        last_in_pass_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_out_o
);
  import mcin_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e     state_q;
  step_cnt_t  cnt_q;
  chan_t      running_max_q, running_max_d;
  chan_t      scale_max_q;
  logic [31:0] px_q;
  logic       out_valid_q;
  logic [31:0] pixel_out_q;

  logic       accept;
  logic       out_free;
  lane_ctrl_t lane_ctrl;
  chan_t      cand_r, cand_g, cand_b;
  chan_t      quot_r, quot_g, quot_b;
  chan_t      lane_max;
  logic [31:0] merged_px;

  // handshake
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  // lane control
  assign lane_ctrl.load = accept && (cmd_i == CmdRewrite);
  assign lane_ctrl.step = (state_q == StDiv);

  // color lanes
  mcin_lane u_lane_r (
    .clk_i       (clk_i),
    .ctrl_i      (lane_ctrl),
    .chan_i      (pixel_in_i[23:16]),
    .run_max_i   (running_max_q),
    .scale_max_i (scale_max_q),
    .cand_o      (cand_r),
    .quot_o      (quot_r)
  );

  mcin_lane u_lane_g (
    .clk_i       (clk_i),
    .ctrl_i      (lane_ctrl),
    .chan_i      (pixel_in_i[15:8]),
    .run_max_i   (running_max_q),
    .scale_max_i (scale_max_q),
    .cand_o      (cand_g),
    .quot_o      (quot_g)
  );

  mcin_lane u_lane_b (
    .clk_i       (clk_i),
    .ctrl_i      (lane_ctrl),
    .chan_i      (pixel_in_i[7:0]),
    .run_max_i   (running_max_q),
    .scale_max_i (scale_max_q),
    .cand_o      (cand_b),
    .quot_o      (quot_b)
  );

  // merging stage
  mcin_merge u_merge (
    .cand_r_i (cand_r),
    .cand_g_i (cand_g),
    .cand_b_i (cand_b),
    .quot_r_i (quot_r),
    .quot_g_i (quot_g),
    .quot_b_i (quot_b),
    .pixel_i  (px_q),
    .max_o    (lane_max),
    .pixel_o  (merged_px)
  );

  // running maximum after a measure request
  assign running_max_d = (pixel_in_i[31:24] != '0) ? lane_max : running_max_q;

  // measure state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_max_q <= '0;
      scale_max_q   <= '0;
    end else if (accept && (cmd_i == CmdMeasure)) begin
      if (last_in_pass_i) begin
        scale_max_q   <= running_max_d;
        running_max_q <= '0;
      end else begin
        running_max_q <= running_max_d;
      end
    end
  end

  // held rewrite pixel
  always_ff @(posedge clk_i) begin
    if (lane_ctrl.load) begin
      px_q <= pixel_in_i;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pixel_out_q <= '0;
    end else begin
      // result valid: set on a new result, cleared when taken
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (lane_ctrl.load) begin
            cnt_q <= '0;
            if (pixel_in_i[31:24] == '0) begin
              state_q <= StDone;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (cnt_q == step_cnt_t'(StepCycles - 1)) begin
            state_q <= StDone;
          end else begin
            cnt_q <= cnt_q + step_cnt_t'(1);
          end
        end
        StDone: begin
          if (out_free) begin
            pixel_out_q <= merged_px;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;

endmodule

`default_nettype wire

@@ hdl/mcin_lane.sv @@
// one color lane: maximum candidate and radix-4 restoring divider
`default_nettype none

module mcin_lane (
  input  logic               clk_i,
  input  mcin_pkg::lane_ctrl_t ctrl_i,
  input  mcin_pkg::chan_t    chan_i,
  input  mcin_pkg::chan_t    run_max_i,
  input  mcin_pkg::chan_t    scale_max_i,
  output mcin_pkg::chan_t    cand_o,
  output mcin_pkg::chan_t    quot_o
);
  import mcin_pkg::*;

  chan_t                rem_q, rem_d;
  chan_t                low_q, low_d;
  logic                 sat_q;
  chan_t                div;
  logic [2*ChanW-1:0]   prod;
  logic [ChanW:0]       rem9;
  chan_t                rem;
  chan_t                low;

  // candidate for the running maximum
  assign cand_o = (chan_i > run_max_i) ? chan_i : run_max_i;

  // zero maximum divides by one
  assign div = (scale_max_i == '0) ? chan_t'(1) : scale_max_i;

  // dividend 255*c as (c << 8) - c
  assign prod = {chan_i, {ChanW{1'b0}}} - {{ChanW{1'b0}}, chan_i};

  // two quotient bits per cycle
  always_comb begin
    rem  = rem_q;
    low  = low_q;
    rem9 = '0;
    for (int unsigned i = 0; i < BitsPerCycle; i++) begin
      rem9 = {rem, low[ChanW-1]};
      low  = {low[ChanW-2:0], 1'b0};
      if (rem9 >= {1'b0, div}) begin
        rem9   = rem9 - {1'b0, div};
        low[0] = 1'b1;
      end
      rem = rem9[ChanW-1:0];
    end
    rem_d = rem;
    low_d = low;
  end

  // divider state
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= prod[2*ChanW-1:ChanW];
      low_q <= prod[ChanW-1:0];
      sat_q <= (chan_i > scale_max_i);
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  // channel above the frozen maximum saturates
  assign quot_o = sat_q ? ChanFull : low_q;

endmodule

`default_nettype wire

@@ hdl/mcin_merge.sv @@
// merging stage: maximum over the lanes and result pixel assembly
`default_nettype none

module mcin_merge (
  input  mcin_pkg::chan_t   cand_r_i,
  input  mcin_pkg::chan_t   cand_g_i,
  input  mcin_pkg::chan_t   cand_b_i,
  input  mcin_pkg::chan_t   quot_r_i,
  input  mcin_pkg::chan_t   quot_g_i,
  input  mcin_pkg::chan_t   quot_b_i,
  input  logic [31:0]       pixel_i,
  output mcin_pkg::chan_t   max_o,
  output logic [31:0]       pixel_o
);
  import mcin_pkg::*;

  chan_t max_rg;

  // maximum of the three lane candidates
  assign max_rg = (cand_r_i > cand_g_i) ? cand_r_i : cand_g_i;
  assign max_o  = (max_rg > cand_b_i) ? max_rg : cand_b_i;

  // transparent pixel passes, others become opaque and stretched
  assign pixel_o = (pixel_i[31:24] == '0) ? pixel_i
                                          : {ChanFull, quot_r_i, quot_g_i, quot_b_i};

endmodule

`default_nettype wire

@@ hdl/mcin_checker.sv @@
// port-level checker for the max-channel image normalize block
`default_nettype none

module mcin_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pixel_out_o
);
  import mcin_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("stalled result changed");

  // a measure request never creates a result
  a_measure_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CmdMeasure) && !out_valid_o |=> !out_valid_o)
    else $error("measure request produced a result");

  // a rewrite request holds off the input in the following cycle
  a_rewrite_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CmdRewrite) |=> in_stall_o)
    else $error("rewrite request did not hold off the input");

  // result alpha is transparent or opaque
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_out_o[31:24] == 8'h00) || (pixel_out_o[31:24] == ChanFull))
    else $error("result alpha neither zero nor full");

endmodule

bind max_channel_image_normalize_core mcin_checker u_mcin_checker (.*);

`default_nettype wire
